// ----- sv/rip_pkg.sv -----
package rip_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CODE_WIDTH  = 2;

   // stack entry codes, numeric order is the operator priority
   typedef enum logic [CODE_WIDTH-1:0] {
      OP_ALT  = 2'd0,
      OP_CAT  = 2'd1,
      OP_STAR = 2'd2,
      OP_OPEN = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_CHAR = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_CAT    = 8'h2e;
   localparam logic [7:0] CH_ALT    = 8'h2b;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7a;

   typedef struct packed {
      logic        push;
      logic        pop;
      logic        clear;
      op_code_type code;
   } stack_cmd_type;

   typedef struct packed {
      logic        empty;
      logic        full;
      op_code_type top;
   } stack_status_type;

   function automatic logic [7:0] code_char(input op_code_type code);
      logic [7:0] ch;
      case (code)
         OP_ALT:  ch = CH_ALT;
         OP_CAT:  ch = CH_CAT;
         OP_STAR: ch = CH_STAR;
         OP_OPEN: ch = CH_OPEN;
         default: ch = CH_OPEN;
      endcase
      return ch;
   endfunction

   function automatic logic is_allowed(input logic [7:0] c);
      return c inside {[CH_ZERO:CH_NINE], [CH_LOW_A:CH_LOW_Z],
                       CH_STAR, CH_CAT, CH_ALT, CH_OPEN, CH_CLOSE, CH_DOLLAR};
   endfunction

endpackage

// ----- sv/rip_if.sv -----
interface rip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       final_char;

   modport source (output valid, output character, output final_char, input ready);
   modport sink   (input valid, input character, input final_char, output ready);
endinterface

interface rip_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       has_symbol;
   logic       end_of_run;
   logic       expr_done;
   logic [1:0] status;

   modport source (output valid, output symbol, output has_symbol, output end_of_run,
                   output expr_done, output status, input ready);
   modport sink   (input valid, input symbol, input has_symbol, input end_of_run,
                   input expr_done, input status, output ready);
endinterface

// ----- sv/rip_ram.sv -----
module rip_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/rip_stack.sv -----
module rip_stack #(
   parameter int STACK_DEPTH = rip_pkg::STACK_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rip_pkg::stack_cmd_type    cmd,
   output rip_pkg::stack_status_type status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CW-1:0]              count_ff, count_in;
   rip_pkg::op_code_type       top_ff, top_in;
   logic [rip_pkg::CODE_WIDTH-1:0] below_data;
   logic [CW-1:0]              rd_index;

   // the ram always presents the entry just below the next top
   assign rd_index = count_in - CW'(2);

   rip_ram #(
      .WIDTH (rip_pkg::CODE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cmd.code),
      .rd_addr (rd_index[AW-1:0]),
      .rd_data (below_data)
   );

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CW'(1);
         top_in   = cmd.code;
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
         top_in   = rip_pkg::op_code_type'(below_data);
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(STACK_DEPTH));
   assign status.top   = top_ff;

endmodule

// ----- sv/rip_seq.sv -----
module rip_seq (
   input  logic                      clock,
   input  logic                      reset,
   rip_req_if.sink                   req_chan,
   rip_rsp_if.source                 rsp_chan,
   output rip_pkg::stack_cmd_type    stack_cmd,
   input  rip_pkg::stack_status_type stack_st
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPER,
      S_CHAR,
      S_CLOSE,
      S_FLUSH,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [7:0]           char_ff, char_in;
   logic                 fin_ff, fin_in;
   rip_pkg::op_code_type prio_ff, prio_in;
   logic                 then_char_ff, then_char_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [7:0]           pend_sym_ff, pend_sym_in;
   rip_pkg::status_type  err_ff, err_in;
   logic [7:0]           prev_ff, prev_in;
   logic                 have_prev_ff, have_prev_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_symbol_ff, rsp_symbol_in;
   logic                 rsp_has_ff, rsp_has_in;
   logic                 rsp_end_ff, rsp_end_in;
   logic                 rsp_done_ff, rsp_done_in;
   rip_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                 out_free;
   logic                 emit_ok;
   logic                 top_pops;
   logic                 implicit_cat;
   logic                 do_emit;
   logic [7:0]           emit_sym;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // a new symbol can be taken once the held one can move to the output
   assign emit_ok  = !pend_valid_ff || out_free;
   assign top_pops = !stack_st.empty && (stack_st.top != rip_pkg::OP_OPEN);

   assign implicit_cat = have_prev_ff &&
      !(prev_ff inside {rip_pkg::CH_OPEN, rip_pkg::CH_CAT, rip_pkg::CH_ALT}) &&
      !(req_chan.character inside
        {rip_pkg::CH_CLOSE, rip_pkg::CH_STAR, rip_pkg::CH_ALT, rip_pkg::CH_CAT});

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      char_in       = char_ff;
      fin_in        = fin_ff;
      prio_in       = prio_ff;
      then_char_in  = then_char_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      err_in        = err_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      stack_cmd     = '0;
      do_emit       = 1'b0;
      emit_sym      = rip_pkg::code_char(stack_st.top);

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               char_in      = req_chan.character;
               fin_in       = req_chan.final_char;
               prev_in      = req_chan.character;
               have_prev_in = 1'b1;
               then_char_in = 1'b0;
               if (err_ff != rip_pkg::ST_OK) begin
                  state_in = S_FINISH;
               end else if (!rip_pkg::is_allowed(req_chan.character)) begin
                  err_in   = rip_pkg::ST_BAD_CHAR;
                  state_in = S_FINISH;
               end else if (implicit_cat) begin
                  prio_in      = rip_pkg::OP_CAT;
                  then_char_in = 1'b1;
                  state_in     = S_OPER;
               end else begin
                  state_in = S_CHAR;
               end
            end
         end
         S_OPER: begin
            if (top_pops && (prio_ff <= stack_st.top)) begin
               if (emit_ok) begin
                  stack_cmd.pop = 1'b1;
                  do_emit       = 1'b1;
               end
            end else if (stack_st.full) begin
               err_in   = rip_pkg::ST_OVERFLOW;
               state_in = S_FINISH;
            end else begin
               stack_cmd.push = 1'b1;
               stack_cmd.code = prio_ff;
               then_char_in   = 1'b0;
               state_in       = then_char_ff ? S_CHAR : S_FLUSH;
            end
         end
         S_CHAR: begin
            case (char_ff)
               rip_pkg::CH_OPEN: begin
                  if (stack_st.full) begin
                     err_in   = rip_pkg::ST_OVERFLOW;
                     state_in = S_FINISH;
                  end else begin
                     stack_cmd.push = 1'b1;
                     stack_cmd.code = rip_pkg::OP_OPEN;
                     state_in       = S_FLUSH;
                  end
               end
               rip_pkg::CH_CLOSE: state_in = S_CLOSE;
               rip_pkg::CH_STAR: begin
                  prio_in  = rip_pkg::OP_STAR;
                  state_in = S_OPER;
               end
               rip_pkg::CH_CAT: begin
                  prio_in  = rip_pkg::OP_CAT;
                  state_in = S_OPER;
               end
               rip_pkg::CH_ALT: begin
                  prio_in  = rip_pkg::OP_ALT;
                  state_in = S_OPER;
               end
               default: begin
                  if (emit_ok) begin
                     do_emit  = 1'b1;
                     emit_sym = char_ff;
                     state_in = S_FLUSH;
                  end
               end
            endcase
         end
         S_CLOSE: begin
            if (top_pops) begin
               if (emit_ok) begin
                  stack_cmd.pop = 1'b1;
                  do_emit       = 1'b1;
               end
            end else begin
               // drop the matching open, or nothing when unmatched
               stack_cmd.pop = !stack_st.empty;
               state_in      = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (fin_ff && !stack_st.empty) begin
               if (emit_ok) begin
                  stack_cmd.pop = 1'b1;
                  do_emit       = 1'b1;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = pend_valid_ff ? pend_sym_ff : 8'd0;
               rsp_has_in    = pend_valid_ff;
               rsp_end_in    = 1'b1;
               rsp_done_in   = fin_ff;
               rsp_status_in = err_ff;
               pend_valid_in = 1'b0;
               if (fin_ff) begin
                  stack_cmd.clear = 1'b1;
                  err_in          = rip_pkg::ST_OK;
                  prev_in         = 8'd0;
                  have_prev_in    = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // the last symbol of a request is held back until its status is final
      if (do_emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = pend_sym_ff;
            rsp_has_in    = 1'b1;
            rsp_end_in    = 1'b0;
            rsp_done_in   = 1'b0;
            rsp_status_in = err_ff;
         end
         pend_valid_in = 1'b1;
         pend_sym_in   = emit_sym;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      fin_ff        <= fin_in;
      prio_ff       <= prio_in;
      pend_sym_ff   <= pend_sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         then_char_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         err_ff        <= rip_pkg::ST_OK;
         prev_ff       <= 8'd0;
         have_prev_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         then_char_ff  <= then_char_in;
         pend_valid_ff <= pend_valid_in;
         err_ff        <= err_in;
         prev_ff       <= prev_in;
         have_prev_ff  <= have_prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.symbol     = rsp_symbol_ff;
   assign rsp_chan.has_symbol = rsp_has_ff;
   assign rsp_chan.end_of_run = rsp_end_ff;
   assign rsp_chan.expr_done  = rsp_done_ff;
   assign rsp_chan.status     = rsp_status_ff;

endmodule

// ----- sv/regex_infix_to_postfix_unit.sv -----
// channel    direction  payload
// req_chan   in         character[7:0], final_char
// rsp_chan   out        symbol[7:0], has_symbol, end_of_run, expr_done, status[1:0]
//
// a request is accepted, decoded, checked for the final flush and answered; an
// implicit '.', an operator and a ')' each add a step that pops stack entries,
// and a final character adds a flush of the remaining entries.
// a rejected byte, or any request after an error, goes straight to the result.
// req_chan is ready only in the idle state; a stalled rsp_chan holds the
// sequencer whenever a symbol or the end result needs the output register.
// synchronous reset empties the stack and clears the error state.
module regex_infix_to_postfix_unit #(
   parameter int STACK_DEPTH = rip_pkg::STACK_DEPTH
) (
   input logic       clock,
   input logic       reset,
   rip_req_if.sink   req_chan,
   rip_rsp_if.source rsp_chan
);

   rip_pkg::stack_cmd_type    stack_cmd;
   rip_pkg::stack_status_type stack_st;

   rip_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stack_cmd),
      .status (stack_st)
   );

   rip_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .stack_cmd (stack_cmd),
      .stack_st  (stack_st)
   );

endmodule
